// File: rtl/core/bcci_pkg.sv
// ----------------------------------------------------------------------------
// bcci_pkg
// Shared types, codes and the cosine easing weight function.
// ----------------------------------------------------------------------------
package bcci_pkg;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_QUERY  = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef struct packed {
    logic        [31:0] pos;
    logic signed [23:0] val;
  } entry_t;

  localparam int ENTRY_W = 56;
  localparam int VALUE_W = 24;
  localparam int WEIGHT_W = 17;
  localparam int PROD_W = 42;

  localparam longint unsigned PI_Q30 = 64'd3373259426;
  localparam longint ONE_Q30 = 64'sd1073741824;

  // weight (1 - cos(pi k / 2^s)) / 2 in unsigned Q1.16, elaboration only
  function automatic logic [31:0] ease_weight(input int k, input int s);
    longint unsigned ang;
    longint unsigned a2;
    longint unsigned term;
    longint c;
    longint unsigned w;
    int kk;
    logic mir;
    kk  = k;
    mir = 1'b0;
    if (k > (1 << (s - 1))) begin
      kk  = (1 << s) - k;
      mir = 1'b1;
    end
    ang  = (PI_Q30 * longint'(kk)) >> s;
    a2   = (ang * ang) >> 30;
    term = 64'd1073741824;
    c    = ONE_Q30;
    term = ((term * a2) >> 30) / 2;   c = c - longint'(term);
    term = ((term * a2) >> 30) / 12;  c = c + longint'(term);
    term = ((term * a2) >> 30) / 30;  c = c - longint'(term);
    term = ((term * a2) >> 30) / 56;  c = c + longint'(term);
    term = ((term * a2) >> 30) / 90;  c = c - longint'(term);
    term = ((term * a2) >> 30) / 132; c = c + longint'(term);
    term = ((term * a2) >> 30) / 182; c = c - longint'(term);
    if (c < 0) c = 0;
    if (c > ONE_Q30) c = ONE_Q30;
    w = (longint'(ONE_Q30 - c) + 64'd16384) >> 15;
    if (mir) w = 64'd65536 - w;
    return w[31:0];
  endfunction

endpackage

// File: rtl/core/bcci_ram.sv
// ----------------------------------------------------------------------------
// bcci_ram
// Generic single write, single read RAM with registered read data.
// ----------------------------------------------------------------------------
module bcci_ram #(
  parameter int WIDTH = 56,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [0:DEPTH-1];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/core/breakpoint_curve_cosine_interp.sv
// ----------------------------------------------------------------------------
// breakpoint_curve_cosine_interp
// Sorted breakpoint table with cosine eased interpolation between points.
// ----------------------------------------------------------------------------
// Clear, no-op, dropped append, query on an empty table and append into an empty
// table go straight to the result; other appends shift up to MAX_POINTS-1 entries,
// one RAM read/write per cycle. Query scans points, then when eased runs a restoring
// divide, multiply and round.
// One request in flight; the next is taken as soon as the result is registered.
// Synchronous active-low reset empties the table; RAM contents are not cleared.
module breakpoint_curve_cosine_interp #(
  parameter int MAX_POINTS        = 64,
  parameter int WEIGHT_STEPS_LOG2 = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [55:0] in_tdata,   // position[31:0], point_value[55:32]
  input  logic [1:0]  in_tuser,   // func[1:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata   // curve_value[23:0], point_count[30:24], table_full[31]
);

  localparam int AW    = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CW    = $clog2(MAX_POINTS + 1);
  localparam int S     = WEIGHT_STEPS_LOG2;
  localparam int STEPS = 1 << S;
  localparam int RW    = 34 + S;
  localparam int IW    = $clog2(S + 2);

  typedef enum logic [6:0] {
    ST_IDLE = 7'b0000001,
    ST_INS  = 7'b0000010,
    ST_PUT  = 7'b0000100,
    ST_QRY  = 7'b0001000,
    ST_DIV  = 7'b0010000,
    ST_MUL  = 7'b0100000,
    ST_FIN  = 7'b1000000
  } state_t;

  state_t                        state_r, state_nxt;
  logic                          sum_r, sum_nxt;
  logic [31:0]                   x_r, x_nxt;
  logic signed [23:0]            val_r, val_nxt;
  logic [AW-1:0]                 idx_r, idx_nxt;
  logic [CW-1:0]                 cnt_r, cnt_nxt;
  bcci_pkg::entry_t              prev_r, prev_nxt;
  logic                          full_r, full_nxt;
  logic signed [23:0]            res_r, res_nxt;
  logic signed [24:0]            diff_r, diff_nxt;
  logic [RW-1:0]                 rem_r, rem_nxt;
  logic [RW-1:0]                 div_r, div_nxt;
  logic [S:0]                    q_r, q_nxt;
  logic [IW-1:0]                 it_r, it_nxt;
  logic signed [bcci_pkg::PROD_W-1:0] prod_r, prod_nxt;
  logic                          ovalid_r, ovalid_nxt;
  logic [31:0]                   odata_r, odata_nxt;

  logic                          ram_we;
  logic [AW-1:0]                 ram_waddr, ram_raddr;
  bcci_pkg::entry_t              ram_wdata, rd;
  logic [bcci_pkg::ENTRY_W-1:0]  ram_rdata;
  logic [bcci_pkg::WEIGHT_W-1:0] wrom [0:STEPS];
  logic                          acc;
  bcci_pkg::op_t                 op_in;
  logic [31:0]                   off, dlt;

  for (genvar k = 0; k <= STEPS; k++) begin : g_wrom
    assign wrom[k] = bcci_pkg::WEIGHT_W'(bcci_pkg::ease_weight(k, S));
  end

  bcci_ram #(
    .WIDTH(bcci_pkg::ENTRY_W),
    .DEPTH(MAX_POINTS)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  assign rd        = bcci_pkg::entry_t'(ram_rdata);
  assign in_tready = (state_r == ST_IDLE);
  assign acc       = in_tvalid && in_tready;
  assign op_in     = bcci_pkg::op_t'(in_tuser);
  assign out_tvalid = ovalid_r;
  assign out_tdata  = odata_r;
  assign off = x_r - prev_r.pos;
  assign dlt = rd.pos - prev_r.pos;

  always_comb begin
    state_nxt  = state_r;
    sum_nxt    = sum_r;
    x_nxt      = x_r;
    val_nxt    = val_r;
    idx_nxt    = idx_r;
    cnt_nxt    = cnt_r;
    prev_nxt   = prev_r;
    full_nxt   = full_r;
    res_nxt    = res_r;
    diff_nxt   = diff_r;
    rem_nxt    = rem_r;
    div_nxt    = div_r;
    q_nxt      = q_r;
    it_nxt     = it_r;
    prod_nxt   = prod_r;
    ovalid_nxt = ovalid_r;
    odata_nxt  = odata_r;
    ram_we     = 1'b0;
    ram_waddr  = idx_r;
    ram_wdata  = rd;
    ram_raddr  = idx_r;

    if (ovalid_r && out_tready) begin
      ovalid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (acc) begin
          x_nxt    = in_tdata[31:0];
          val_nxt  = in_tdata[55:32];
          full_nxt = 1'b0;
          res_nxt  = '0;
          sum_nxt  = 1'b0;
          state_nxt = ST_FIN;
          unique case (op_in)
            bcci_pkg::OP_CLEAR: begin
              cnt_nxt = '0;
            end
            bcci_pkg::OP_APPEND: begin
              if (cnt_r >= CW'(MAX_POINTS)) begin
                full_nxt = 1'b1;
              end else if (cnt_r == '0) begin
                ram_we    = 1'b1;
                ram_waddr = '0;
                ram_wdata = {in_tdata[31:0], in_tdata[55:32]};
                cnt_nxt   = cnt_r + 1'b1;
              end else begin
                idx_nxt   = cnt_r[AW-1:0];
                ram_raddr = AW'(cnt_r - 1'b1);
                state_nxt = ST_INS;
              end
            end
            bcci_pkg::OP_QUERY: begin
              if (cnt_r != '0) begin
                idx_nxt   = '0;
                ram_raddr = '0;
                state_nxt = ST_QRY;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_INS: begin
        ram_we    = 1'b1;
        ram_waddr = idx_r;
        if (rd.pos > x_r) begin
          ram_wdata = rd;
          idx_nxt   = idx_r - 1'b1;
          ram_raddr = idx_r - AW'(2);
          if (idx_r == AW'(1)) begin
            state_nxt = ST_PUT;
          end
        end else begin
          ram_wdata = {x_r, val_r};
          cnt_nxt   = cnt_r + 1'b1;
          state_nxt = ST_FIN;
        end
      end
      ST_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = '0;
        ram_wdata = {x_r, val_r};
        cnt_nxt   = cnt_r + 1'b1;
        state_nxt = ST_FIN;
      end
      ST_QRY: begin
        if (idx_r == '0 && (x_r <= rd.pos || cnt_r == CW'(1))) begin
          res_nxt   = rd.val;
          state_nxt = ST_FIN;
        end else if (idx_r != '0 && rd.pos >= x_r) begin
          if (rd.val == prev_r.val) begin
            res_nxt   = rd.val;
            state_nxt = ST_FIN;
          end else begin
            diff_nxt  = 25'(rd.val) - 25'(prev_r.val);
            rem_nxt   = (RW'(off) << (S + 1)) + RW'(dlt);
            div_nxt   = RW'(dlt) << (S + 1);
            q_nxt     = '0;
            it_nxt    = IW'(S + 1);
            state_nxt = ST_DIV;
          end
        end else if (CW'(idx_r) == cnt_r - 1'b1) begin
          res_nxt   = rd.val;
          state_nxt = ST_FIN;
        end else begin
          prev_nxt  = rd;
          idx_nxt   = idx_r + 1'b1;
          ram_raddr = idx_r + 1'b1;
        end
      end
      ST_DIV: begin
        if (rem_r >= div_r) begin
          rem_nxt = rem_r - div_r;
          q_nxt   = {q_r[S-1:0], 1'b1};
        end else begin
          q_nxt   = {q_r[S-1:0], 1'b0};
        end
        div_nxt = div_r >> 1;
        it_nxt  = it_r - 1'b1;
        if (it_r == IW'(1)) begin
          state_nxt = ST_MUL;
          sum_nxt   = 1'b0;
        end
      end
      ST_MUL: begin
        if (!sum_r) begin
          prod_nxt = bcci_pkg::PROD_W'($signed({1'b0, wrom[q_r]}) * diff_r);
          sum_nxt  = 1'b1;
        end else begin
          res_nxt   = prev_r.val + 24'((prod_r + 42'sd32768) >>> 16);
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        if (!ovalid_r || out_tready) begin
          ovalid_nxt = 1'b1;
          odata_nxt  = {full_r, 7'(cnt_r), res_r};
          state_nxt  = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_IDLE;
      cnt_r    <= '0;
      ovalid_r <= 1'b0;
      sum_r    <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      cnt_r    <= cnt_nxt;
      ovalid_r <= ovalid_nxt;
      sum_r    <= sum_nxt;
    end
    x_r     <= x_nxt;
    val_r   <= val_nxt;
    idx_r   <= idx_nxt;
    prev_r  <= prev_nxt;
    full_r  <= full_nxt;
    res_r   <= res_nxt;
    diff_r  <= diff_nxt;
    rem_r   <= rem_nxt;
    div_r   <= div_nxt;
    q_r     <= q_nxt;
    it_r    <= it_nxt;
    prod_r  <= prod_nxt;
    odata_r <= odata_nxt;
  end

`ifndef SYNTHESIS
  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MAX_POINTS))
    else $error("point count above table size");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_tuser == bcci_pkg::OP_CLEAR) |=> cnt_r == '0)
    else $error("clear did not empty table");
  a_quot: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> q_r <= (S + 1)'(STEPS))
    else $error("weight index out of range");
  a_idle_wr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE && !acc) |-> !ram_we)
    else $error("table write while idle");
`endif

endmodule
